/* src/sks_pkg.sv */
// Shared types, register indexes and saturation helper for the two-bone skinning block.
// No dependencies; used by every module under src.
`default_nettype none
package sks_pkg;

	typedef logic signed [15:0] s16_t;
	typedef s16_t [2:0] vec3_t;

	localparam int unsigned NUM_CFG   = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 48;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_A_ROW0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_A_ROW1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_A_ROW2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_B_ROW0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_B_ROW1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_B_ROW2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANS_A    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANS_B    = 3'd7;

	// Q12 unity weight
	localparam logic [12:0] Q_ONE = 13'h1000;

	localparam logic signed [21:0] SAT_MAX = 22'sd32767;
	localparam logic signed [21:0] SAT_MIN = -22'sd32768;

	typedef struct packed {
		logic signed [15:0] vert_x;
		logic signed [15:0] vert_y;
		logic signed [15:0] vert_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic               has_normal;
		logic [12:0]        weight;
		logic [47:0]        offset_a_xyz;
		logic [47:0]        offset_b_xyz;
	} in_req_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
		logic signed [15:0] out_nx;
		logic signed [15:0] out_ny;
		logic signed [15:0] out_nz;
		logic               normal_valid;
	} out_req_t;

	// Clamp a 22-bit signed value to the 16-bit signed range
	function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
		logic signed [15:0] r;
		if (v > SAT_MAX) begin
			r = 16'sh7fff;
		end else if (v < SAT_MIN) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/sks_rot3.sv */
// Two-stage Q12 3x3 matrix-vector rotate with saturation and wrapped translation add.
// Depends on sks_pkg for vector types and the saturation helper.
`default_nettype none
module sks_rot3 (
	input  wire logic                clk,
	input  wire logic                en_s2,
	input  wire logic                en_s3,
	input  wire sks_pkg::vec3_t      vec,
	input  wire logic [2:0][47:0]    mat,
	input  wire logic [47:0]         trans,
	output sks_pkg::vec3_t           res_s3
);

	logic signed [31:0] prod_s2 [3][3];
	logic [47:0]        trans_s2;
	sks_pkg::vec3_t     res_d;

	// Form all nine coefficient products
	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[r][c] <= $signed(mat[r][16*c +: 16]) * $signed(vec[c]);
				end
			end
			trans_s2 <= trans;
		end
	end

	// Sum each row, floor-shift by 12, clamp, then add translation with wrap
	always_comb begin
		logic signed [33:0] acc;
		logic signed [21:0] sh;
		logic signed [15:0] sat;
		logic        [15:0] sum;
		acc = '0;
		sh  = '0;
		sat = '0;
		sum = '0;
		for (int r = 0; r < 3; r++) begin
			acc = 34'(prod_s2[r][0]) + 34'(prod_s2[r][1]) + 34'(prod_s2[r][2]);
			sh  = 22'(acc >>> 12);
			sat = sks_pkg::sat16(sh);
			sum = 16'(sat + $signed(trans_s2[16*r +: 16]));
			res_d[r] = $signed(sum);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			res_s3 <= res_d;
		end
	end

endmodule
`default_nettype wire

/* src/sks_blend.sv */
// Q12 weighted blend of two bone results: registered products, then sum, shift and clamp.
// Depends on sks_pkg for vector types, Q_ONE and the saturation helper.
`default_nettype none
module sks_blend (
	input  wire logic            clk,
	input  wire logic            en_s4,
	input  wire logic [12:0]     weight,
	input  wire sks_pkg::vec3_t  a,
	input  wire sks_pkg::vec3_t  b,
	output sks_pkg::vec3_t       res
);

	logic signed [29:0] pa_s4 [3];
	logic signed [29:0] pb_s4 [3];
	sks_pkg::vec3_t     a_s4;
	sks_pkg::vec3_t     b_s4;
	logic               pick_a_s4;
	logic               pick_b_s4;
	logic signed [13:0] w_sgn;
	logic signed [13:0] wb;

	// Weights as signed 14-bit; weights above unity give a negative B share
	assign w_sgn = $signed({1'b0, weight});
	assign wb    = 14'sd4096 - w_sgn;

	// Register products and the endpoint selects
	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int k = 0; k < 3; k++) begin
				pa_s4[k] <= w_sgn * $signed(a[k]);
				pb_s4[k] <= wb * $signed(b[k]);
			end
			a_s4      <= a;
			b_s4      <= b;
			pick_a_s4 <= (weight == sks_pkg::Q_ONE);
			pick_b_s4 <= (weight == '0);
		end
	end

	// Combine, floor-shift by 12 and clamp, or pass an endpoint through
	always_comb begin
		logic signed [31:0] sum;
		logic signed [19:0] sh;
		sum = '0;
		sh  = '0;
		for (int k = 0; k < 3; k++) begin
			sum = 32'(pa_s4[k]) + 32'(pb_s4[k]);
			sh  = 20'(sum >>> 12);
			if (pick_a_s4) begin
				res[k] = a_s4[k];
			end else if (pick_b_s4) begin
				res[k] = b_s4[k];
			end else begin
				res[k] = sks_pkg::sat16(22'(sh));
			end
		end
	end

endmodule
`default_nettype wire

/* src/two_bone_vertex_skinning.sv */
// Top level of the two-bone Q12 vertex skinning pipeline: config registers, stage control.
// Depends on sks_pkg, sks_rot3 and sks_blend.
//
//  port group    dir   handshake              payload
//  in_*          in    in_valid / in_ready    in_data  (sks_pkg::in_req_t)
//  out_*         out   out_valid / out_ready  out_data (sks_pkg::out_req_t)
//  cfg_*         in    cfg_wr_en              cfg_index, cfg_data
//
// Five register stages: offset add, coefficient products, row reduce, blend products,
// blend reduce into the output register. One request per cycle when the output is not stalled.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// collapse and a stalled output holds while earlier stages keep filling.
// Reset clears the valid bits and the configuration registers.
`default_nettype none
module two_bone_vertex_skinning (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire sks_pkg::in_req_t                    in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output sks_pkg::out_req_t                        out_data,
	input  wire logic                                cfg_wr_en,
	input  wire logic [sks_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sks_pkg::CFG_W-1:0]           cfg_data
);

	logic [sks_pkg::CFG_W-1:0] cfg_q [sks_pkg::NUM_CFG];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	sks_pkg::vec3_t pa_s1, pb_s1, norm_s1, norm_s2, norm_s3, norm_s4;
	logic           hn_s1, hn_s2, hn_s3, hn_s4;
	logic [12:0]    w_s1, w_s2, w_s3;

	sks_pkg::vec3_t va_s3, vb_s3, na_s3, nb_s3;
	sks_pkg::vec3_t vert_mix, norm_mix;
	sks_pkg::vec3_t vin, nin;
	sks_pkg::vec3_t pa_d, pb_d;
	sks_pkg::out_req_t out_s5;

	logic [2:0][47:0] mat_a, mat_b;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sks_pkg::NUM_CFG; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	assign mat_a = {cfg_q[sks_pkg::CFG_ROT_A_ROW2], cfg_q[sks_pkg::CFG_ROT_A_ROW1],
	                cfg_q[sks_pkg::CFG_ROT_A_ROW0]};
	assign mat_b = {cfg_q[sks_pkg::CFG_ROT_B_ROW2], cfg_q[sks_pkg::CFG_ROT_B_ROW1],
	                cfg_q[sks_pkg::CFG_ROT_B_ROW0]};

	// Stage enables: advance when empty or when downstream advances
	assign en_s5    = !vld_s5 || out_ready;
	assign en_s4    = !vld_s4 || en_s5;
	assign en_s3    = !vld_s3 || en_s4;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// Add per-bone offsets with 16-bit wrap
	assign vin = {in_data.vert_z, in_data.vert_y, in_data.vert_x};
	assign nin = {in_data.norm_z, in_data.norm_y, in_data.norm_x};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pa_d[k] = $signed(16'(vin[k] + in_data.offset_a_xyz[16*k +: 16]));
			pb_d[k] = $signed(16'(vin[k] + in_data.offset_b_xyz[16*k +: 16]));
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pa_s1   <= pa_d;
			pb_s1   <= pb_d;
			norm_s1 <= nin;
			hn_s1   <= in_data.has_normal;
			w_s1    <= in_data.weight;
		end
	end

	// Carry side data alongside the rotate and blend stages
	always_ff @(posedge clk) begin
		if (en_s2) begin
			norm_s2 <= norm_s1;
			hn_s2   <= hn_s1;
			w_s2    <= w_s1;
		end
		if (en_s3) begin
			norm_s3 <= norm_s2;
			hn_s3   <= hn_s2;
			w_s3    <= w_s2;
		end
		if (en_s4) begin
			norm_s4 <= norm_s3;
			hn_s4   <= hn_s3;
		end
	end

	// Rotate vertex and normal by each bone
	sks_rot3 u_rot_va (
		.clk(clk), .en_s2(en_s2), .en_s3(en_s3), .vec(pa_s1), .mat(mat_a),
		.trans(cfg_q[sks_pkg::CFG_TRANS_A]), .res_s3(va_s3)
	);
	sks_rot3 u_rot_vb (
		.clk(clk), .en_s2(en_s2), .en_s3(en_s3), .vec(pb_s1), .mat(mat_b),
		.trans(cfg_q[sks_pkg::CFG_TRANS_B]), .res_s3(vb_s3)
	);
	sks_rot3 u_rot_na (
		.clk(clk), .en_s2(en_s2), .en_s3(en_s3), .vec(norm_s1), .mat(mat_a),
		.trans(48'd0), .res_s3(na_s3)
	);
	sks_rot3 u_rot_nb (
		.clk(clk), .en_s2(en_s2), .en_s3(en_s3), .vec(norm_s1), .mat(mat_b),
		.trans(48'd0), .res_s3(nb_s3)
	);

	// Blend the two bones
	sks_blend u_blend_v (
		.clk(clk), .en_s4(en_s4), .weight(w_s3), .a(va_s3), .b(vb_s3), .res(vert_mix)
	);
	sks_blend u_blend_n (
		.clk(clk), .en_s4(en_s4), .weight(w_s3), .a(na_s3), .b(nb_s3), .res(norm_mix)
	);

	// Load the output register; pass the normal through when absent
	always_ff @(posedge clk) begin
		if (en_s5) begin
			out_s5.out_x        <= vert_mix[0];
			out_s5.out_y        <= vert_mix[1];
			out_s5.out_z        <= vert_mix[2];
			out_s5.out_nx       <= hn_s4 ? norm_mix[0] : norm_s4[0];
			out_s5.out_ny       <= hn_s4 ? norm_mix[1] : norm_s4[1];
			out_s5.out_nz       <= hn_s4 ? norm_mix[2] : norm_s4[2];
			out_s5.normal_valid <= hn_s4;
		end
	end

	assign out_valid = vld_s5;
	assign out_data  = out_s5;

	// An accepted request lands in the first stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s1)
		else $error("accepted request missing from stage 1");

	// An empty first stage always takes a request
	assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> in_ready)
		else $error("input stalled with empty stage 1");

	// Output drains when nothing is behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !vld_s4) |=> !out_valid)
		else $error("output repeated a request");

	// A stalled output keeps the stage behind it from advancing into it
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && !out_ready) |-> !en_s5)
		else $error("output register overwritten while stalled");

endmodule
`default_nettype wire
